// ----- hdl/crh_pkg.sv -----
// Shared types, codes and constants of the capture record header deframer.
`timescale 1ns / 1ps

package crh_pkg;

	localparam int MAX_FIELD_LEN_DEF = 32;
	localparam int SIZE_DIGITS_DEF   = 7;

	localparam int CFG_IDX_W = 2;
	localparam int SIZE_W    = 24;
	localparam int HDR_W     = 10;

	localparam logic [7:0] LEAD_SKIP_RST   = 8'd22;
	localparam logic [7:0] MIDDLE_SKIP_RST = 8'd13;
	localparam logic [7:0] TAIL_SKIP_RST   = 8'd16;

	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_M     = 8'h4D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};
	localparam logic [HDR_W-1:0]  HDR_MAX  = {HDR_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEAD_SKIP   = 2'd0,
		REG_MIDDLE_SKIP = 2'd1,
		REG_TAIL_SKIP   = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		TAG_SIZE    = 3'd0,
		TAG_ADDR    = 3'd1,
		TAG_PORT    = 3'd2,
		TAG_TIME    = 3'd3,
		TAG_PAYLOAD = 3'd4,
		TAG_HDR     = 3'd5,
		TAG_TRAILER = 3'd6
	} tag_t;

	typedef enum logic [3:0] {
		PH_MARK0   = 4'd0,
		PH_MARK1   = 4'd1,
		PH_LEAD    = 4'd2,
		PH_SIZE    = 4'd3,
		PH_ADDR    = 4'd4,
		PH_PORT    = 4'd5,
		PH_MIDDLE  = 4'd6,
		PH_TIME    = 4'd7,
		PH_TAIL    = 4'd8,
		PH_PAYLOAD = 4'd9,
		PH_TRAILER = 4'd10,
		PH_ERROR   = 4'd11
	} phase_t;

	typedef struct packed {
		logic [7:0] lead_skip;
		logic [7:0] middle_skip;
		logic [7:0] tail_skip;
	} cfg_t;

	typedef struct packed {
		tag_t              field_tag;
		logic [7:0]        char_value;
		logic              field_end;
		logic [SIZE_W-1:0] payload_len;
		logic [HDR_W-1:0]  header_length;
		logic              frame_error;
		logic              record_last;
	} res_t;

endpackage

// ----- hdl/crh_if.sv -----
// Handshake channel interfaces: byte input, result output and register writes.
`timescale 1ns / 1ps

interface crh_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface crh_result_if;
	logic                       valid;
	logic                       ready;
	logic [2:0]                 field_tag;
	logic [7:0]                 char_value;
	logic                       field_end;
	logic [crh_pkg::SIZE_W-1:0] payload_len;
	logic [crh_pkg::HDR_W-1:0]  header_length;
	logic                       frame_error;
	logic                       record_last;

	modport source (output valid, output field_tag, output char_value, output field_end,
		output payload_len, output header_length, output frame_error,
		output record_last, input ready);
	modport sink (input valid, input field_tag, input char_value, input field_end,
		input payload_len, input header_length, input frame_error,
		input record_last, output ready);
endinterface

interface crh_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [crh_pkg::CFG_IDX_W-1:0] index;
	logic [7:0]                    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/crh_cfg_regs.sv -----
// Skip length configuration registers.
`timescale 1ns / 1ps

module crh_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [crh_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [7:0]                    wr_data,
	output crh_pkg::cfg_t                 cfg
);

	crh_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lead_skip   <= crh_pkg::LEAD_SKIP_RST;
			cfg_q.middle_skip <= crh_pkg::MIDDLE_SKIP_RST;
			cfg_q.tail_skip   <= crh_pkg::TAIL_SKIP_RST;
		end else if (wr_en) begin
			// Writes to an index past the register list are dropped.
			unique case (wr_index)
				crh_pkg::REG_LEAD_SKIP:   cfg_q.lead_skip   <= wr_data;
				crh_pkg::REG_MIDDLE_SKIP: cfg_q.middle_skip <= wr_data;
				crh_pkg::REG_TAIL_SKIP:   cfg_q.tail_skip   <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hdl/crh_fsm.sv -----
// Record parser: phase state machine, skip and field counters, size accumulator.
`timescale 1ns / 1ps

module crh_fsm #(
	parameter int MAX_FIELD_LEN = crh_pkg::MAX_FIELD_LEN_DEF,
	parameter int SIZE_DIGITS   = crh_pkg::SIZE_DIGITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  logic [7:0]    data_byte,
	input  crh_pkg::cfg_t cfg,
	output logic          res_valid,
	output crh_pkg::res_t res
);

	localparam int FL_W = $clog2(MAX_FIELD_LEN + 1);
	localparam int ACC_W = crh_pkg::SIZE_W + 4;

	crh_pkg::phase_t             phase_q, phase_d;
	logic [7:0]                  skip_q, skip_d;
	logic [FL_W-1:0]             fl_q, fl_d;
	logic [crh_pkg::SIZE_W-1:0]  acc_q, acc_d;
	logic                        stopped_q, stopped_d;
	logic [crh_pkg::HDR_W-1:0]   hdr_q, hdr_d, hdr_inc;
	logic [crh_pkg::SIZE_W-1:0]  rem_q, rem_d, rem_dec;
	logic [7:0]                  skip_dec;
	logic [ACC_W-1:0]            acc_x10;
	logic                        is_slash, is_digit, field_full, digits_full;
	crh_pkg::tag_t               field_tag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= crh_pkg::PH_MARK0;
			skip_q    <= '0;
			fl_q      <= '0;
			acc_q     <= '0;
			stopped_q <= 1'b0;
			hdr_q     <= '0;
			rem_q     <= '0;
		end else if (take) begin
			phase_q   <= phase_d;
			skip_q    <= skip_d;
			fl_q      <= fl_d;
			acc_q     <= acc_d;
			stopped_q <= stopped_d;
			hdr_q     <= hdr_d;
			rem_q     <= rem_d;
		end
	end

	assign is_slash    = (data_byte == crh_pkg::CH_SLASH);
	assign is_digit    = (data_byte >= crh_pkg::CH_ZERO) && (data_byte <= crh_pkg::CH_NINE);
	assign field_full  = {{(32 - FL_W){1'b0}}, fl_q} >= 32'(MAX_FIELD_LEN);
	assign digits_full = {{(32 - FL_W){1'b0}}, fl_q} >= 32'(SIZE_DIGITS);
	assign hdr_inc     = (hdr_q == crh_pkg::HDR_MAX) ? hdr_q : hdr_q + 1'b1;
	assign skip_dec    = skip_q - 8'd1;
	assign rem_dec     = rem_q - 1'b1;
	// Times ten as two shifted copies, plus the digit.
	assign acc_x10     = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
		+ {{(ACC_W - 4){1'b0}}, 4'(data_byte - crh_pkg::CH_ZERO)};

	always_comb begin
		unique case (phase_q)
			crh_pkg::PH_ADDR: field_tag = crh_pkg::TAG_ADDR;
			crh_pkg::PH_PORT: field_tag = crh_pkg::TAG_PORT;
			crh_pkg::PH_TIME: field_tag = crh_pkg::TAG_TIME;
			default:          field_tag = crh_pkg::TAG_SIZE;
		endcase
	end

	always_comb begin
		phase_d   = phase_q;
		skip_d    = skip_q;
		fl_d      = fl_q;
		acc_d     = acc_q;
		stopped_d = stopped_q;
		hdr_d     = hdr_q;
		rem_d     = rem_q;
		res_valid = 1'b0;
		res       = '0;
		res.field_tag  = crh_pkg::TAG_SIZE;
		res.char_value = data_byte;

		unique case (phase_q)
			crh_pkg::PH_MARK0: begin
				if (data_byte != crh_pkg::CH_STAR) begin
					phase_d         = crh_pkg::PH_ERROR;
					res_valid       = 1'b1;
					res.frame_error = 1'b1;
				end else begin
					hdr_d     = crh_pkg::HDR_W'(1);
					acc_d     = '0;
					stopped_d = 1'b0;
					fl_d      = '0;
					phase_d   = crh_pkg::PH_MARK1;
				end
			end
			crh_pkg::PH_MARK1: begin
				if (data_byte != crh_pkg::CH_M) begin
					phase_d         = crh_pkg::PH_ERROR;
					res_valid       = 1'b1;
					res.frame_error = 1'b1;
				end else begin
					hdr_d = hdr_inc;
					if (cfg.lead_skip <= 8'd2) begin
						phase_d = crh_pkg::PH_SIZE;
					end else begin
						skip_d  = cfg.lead_skip - 8'd2;
						phase_d = crh_pkg::PH_LEAD;
					end
				end
			end
			crh_pkg::PH_LEAD, crh_pkg::PH_MIDDLE: begin
				hdr_d  = hdr_inc;
				skip_d = skip_dec;
				if (skip_dec == 8'd0) begin
					phase_d = (phase_q == crh_pkg::PH_LEAD) ? crh_pkg::PH_SIZE
						: crh_pkg::PH_TIME;
				end
			end
			crh_pkg::PH_SIZE, crh_pkg::PH_ADDR, crh_pkg::PH_PORT, crh_pkg::PH_TIME: begin
				hdr_d = hdr_inc;
				res.field_tag = field_tag;
				if (is_slash) begin
					fl_d          = '0;
					res_valid     = 1'b1;
					res.field_end = 1'b1;
					unique case (phase_q)
						crh_pkg::PH_SIZE: phase_d = crh_pkg::PH_ADDR;
						crh_pkg::PH_ADDR: phase_d = crh_pkg::PH_PORT;
						crh_pkg::PH_PORT: begin
							if (cfg.middle_skip != 8'd0) begin
								skip_d  = cfg.middle_skip;
								phase_d = crh_pkg::PH_MIDDLE;
							end else begin
								phase_d = crh_pkg::PH_TIME;
							end
						end
						default: begin
							if (cfg.tail_skip == 8'd0) begin
								// No tail: the closing slash itself reports the header.
								rem_d             = acc_q;
								phase_d           = (acc_q != '0) ? crh_pkg::PH_PAYLOAD
									: crh_pkg::PH_TRAILER;
								res.field_tag     = crh_pkg::TAG_HDR;
								res.payload_len   = acc_q;
								res.header_length = hdr_inc;
							end else begin
								skip_d  = cfg.tail_skip;
								phase_d = crh_pkg::PH_TAIL;
							end
						end
					endcase
				end else if (field_full || (phase_q == crh_pkg::PH_SIZE && !stopped_q
						&& is_digit && digits_full)) begin
					phase_d         = crh_pkg::PH_ERROR;
					res_valid       = 1'b1;
					res.field_tag   = crh_pkg::TAG_SIZE;
					res.frame_error = 1'b1;
				end else begin
					if (phase_q == crh_pkg::PH_SIZE && !stopped_q) begin
						if (is_digit) begin
							acc_d = (acc_x10[ACC_W-1:crh_pkg::SIZE_W] != '0) ? crh_pkg::SIZE_MAX
								: acc_x10[crh_pkg::SIZE_W-1:0];
						end else begin
							stopped_d = 1'b1;
						end
					end
					fl_d      = fl_q + 1'b1;
					res_valid = 1'b1;
				end
			end
			crh_pkg::PH_TAIL: begin
				hdr_d  = hdr_inc;
				skip_d = skip_dec;
				if (skip_dec == 8'd0) begin
					rem_d             = acc_q;
					phase_d           = (acc_q != '0) ? crh_pkg::PH_PAYLOAD : crh_pkg::PH_TRAILER;
					res_valid         = 1'b1;
					res.field_tag     = crh_pkg::TAG_HDR;
					res.payload_len   = acc_q;
					res.header_length = hdr_inc;
				end
			end
			crh_pkg::PH_PAYLOAD: begin
				rem_d         = rem_dec;
				res_valid     = 1'b1;
				res.field_tag = crh_pkg::TAG_PAYLOAD;
				if (rem_dec == '0) begin
					phase_d = crh_pkg::PH_TRAILER;
				end
			end
			crh_pkg::PH_TRAILER: begin
				phase_d         = crh_pkg::PH_MARK0;
				res_valid       = 1'b1;
				res.field_tag   = crh_pkg::TAG_TRAILER;
				res.record_last = 1'b1;
			end
			crh_pkg::PH_ERROR: begin
				phase_d = crh_pkg::PH_ERROR;
			end
			default: begin
				phase_d = crh_pkg::PH_ERROR;
			end
		endcase
	end

endmodule

// ----- hdl/crh_out_reg.sv -----
// Result register between the parser and the output channel.
`timescale 1ns / 1ps

module crh_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  logic          push,
	input  crh_pkg::res_t res,
	output logic          up_ready,
	input  logic          down_ready,
	output logic          out_valid,
	output crh_pkg::res_t out_res
);

	logic          valid_q;
	crh_pkg::res_t res_q;

	// The register can load when it is empty or its result leaves this cycle.
	assign up_ready = !valid_q || down_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= take && push;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && take && push) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

endmodule

// ----- hdl/capture_record_header_deframer.sv -----
// Top level of the capture record header deframer.
//
// Usage:
// bytes carries the raw capture stream, one byte per request. Each record is
// the marker '*','M', a lead, the slash-ended size, address and port fields,
// a middle skip, the time field and a tail skip, then the payload and one
// trailer byte. records carries at most one result per input byte: tagged
// field characters, a header-done result with payload size and header length,
// payload bytes and the trailer marked record_last. Matching marker, lead and
// middle skip bytes give no result, nor do tail bytes but the last, which
// carries the header-done result. cfg writes the lead, middle and tail skip
// registers; write them only while the block is idle. A byte is accepted every
// cycle while the output register can load: the parser state updates in the
// same cycle that a byte is taken and the result lands in a single output
// register, which shows it on records in the cycle after. If records stalls,
// bytes.ready drops only while that register is full and not being drained.
// After reset the skips hold 22, 13 and 16 and the block waits for a record
// marker. A bad marker, an overlong field or too many size digits gives one
// result with frame_error set, after which nothing more is reported until the next reset.
`timescale 1ns / 1ps

module capture_record_header_deframer #(
	parameter int MAX_FIELD_LEN = crh_pkg::MAX_FIELD_LEN_DEF,
	parameter int SIZE_DIGITS   = crh_pkg::SIZE_DIGITS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	crh_byte_if.sink     bytes,
	crh_result_if.source records,
	crh_cfg_if.sink      cfg
);

	crh_pkg::cfg_t cfg_val;
	crh_pkg::res_t res, out_res;
	logic          res_valid;
	logic          up_ready;
	logic          take;

	assign cfg.ready   = 1'b1;
	assign bytes.ready = up_ready;
	assign take        = bytes.valid && up_ready;

	crh_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_val)
	);

	crh_fsm #(
		.MAX_FIELD_LEN (MAX_FIELD_LEN),
		.SIZE_DIGITS   (SIZE_DIGITS)
	) u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (bytes.data_byte),
		.cfg       (cfg_val),
		.res_valid (res_valid),
		.res       (res)
	);

	crh_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.push       (res_valid),
		.res        (res),
		.up_ready   (up_ready),
		.down_ready (records.ready),
		.out_valid  (records.valid),
		.out_res    (out_res)
	);

	assign records.field_tag     = 3'(out_res.field_tag);
	assign records.char_value    = out_res.char_value;
	assign records.field_end     = out_res.field_end;
	assign records.payload_len   = out_res.payload_len;
	assign records.header_length = out_res.header_length;
	assign records.frame_error   = out_res.frame_error;
	assign records.record_last   = out_res.record_last;

endmodule

// ----- dv/capture_record_header_deframer_test.sv -----
// Self-checking testbench for the capture record header deframer.
`timescale 1ns / 1ps

module capture_record_header_deframer_test;
	import crh_pkg::*;

	localparam time         CLK_PERIOD     = 20ns;
	localparam int unsigned RESET_CYCLES   = 9;
	localparam int unsigned HOLD_CYCLES    = 300;
	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned ITEM_TARGET    = 1500;
	localparam int unsigned REPORT_LIMIT   = 10;

	// Index 3 has no register behind it; writes to it must be dropped.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef enum int {SZ_PLAIN, SZ_PADDED, SZ_SUFFIX, SZ_PREFIX, SZ_EMPTY} size_form_t;
	typedef enum int {END_BAD_FIRST, END_BAD_SECOND, END_LONG_FIELD, END_MANY_DIGITS,
		END_HUGE_SIZE} ending_t;
	typedef enum int {DRAIN_FULL, DRAIN_MOSTLY, DRAIN_EVERY_FOURTH, DRAIN_SPARSE} drain_mode_t;

	class deframe_tracker;
		logic [7:0]        lead_skip, middle_skip, tail_skip;
		phase_t            phase;
		logic [7:0]        skip_left, field_len;
		logic [SIZE_W-1:0] size_acc, pay_left;
		logic              digits_done;
		logic [HDR_W-1:0]  hdr_count;
		res_t              expected_records[$];
		int unsigned       mismatches, checked, bytes_in, headers, trailers, errors;

		function new();
			lead_skip = LEAD_SKIP_RST;
			middle_skip = MIDDLE_SKIP_RST;
			tail_skip = TAIL_SKIP_RST;
			phase = PH_MARK0;
			skip_left = '0;
			field_len = '0;
			size_acc = '0;
			pay_left = '0;
			digits_done = 1'b0;
			hdr_count = '0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] v);
			case (idx)
				REG_LEAD_SKIP: lead_skip = v;
				REG_MIDDLE_SKIP: middle_skip = v;
				REG_TAIL_SKIP: tail_skip = v;
				default: ;
			endcase
		endfunction

		function void emit(tag_t tag, logic [7:0] ch, logic fend, logic [SIZE_W-1:0] psize,
				logic [HDR_W-1:0] hlen, logic err, logic last);
			res_t r;
			r.field_tag = tag;
			r.char_value = ch;
			r.field_end = fend;
			r.payload_len = psize;
			r.header_length = hlen;
			r.frame_error = err;
			r.record_last = last;
			expected_records.push_back(r);
		endfunction

		// The parser goes dead after an error and stays silent until reset.
		function void raise_error(logic [7:0] b);
			phase = PH_ERROR;
			emit(TAG_SIZE, b, 1'b0, '0, '0, 1'b1, 1'b0);
		endfunction

		function void count_hdr();
			if (hdr_count < HDR_MAX)
				hdr_count++;
		endfunction

		function void close_header(logic [7:0] b, logic fend);
			pay_left = size_acc;
			phase = (size_acc != 0) ? PH_PAYLOAD : PH_TRAILER;
			emit(TAG_HDR, b, fend, size_acc, hdr_count, 1'b0, 1'b0);
		endfunction

		function void field_byte(logic [7:0] b);
			tag_t tag;
			longint unsigned acc;
			if (phase == PH_SIZE)
				tag = TAG_SIZE;
			else if (phase == PH_ADDR)
				tag = TAG_ADDR;
			else if (phase == PH_PORT)
				tag = TAG_PORT;
			else
				tag = TAG_TIME;
			count_hdr();
			if (b == CH_SLASH) begin
				field_len = '0;
				case (phase)
					PH_SIZE: phase = PH_ADDR;
					PH_ADDR: phase = PH_PORT;
					PH_PORT: begin
						if (middle_skip != 0) begin
							skip_left = middle_skip;
							phase = PH_MIDDLE;
						end else begin
							phase = PH_TIME;
						end
					end
					default: begin
						// With no tail the closing slash itself completes the header.
						if (tail_skip == 0) begin
							close_header(b, 1'b1);
							return;
						end
						skip_left = tail_skip;
						phase = PH_TAIL;
					end
				endcase
				emit(tag, b, 1'b1, '0, '0, 1'b0, 1'b0);
				return;
			end
			if (field_len >= MAX_FIELD_LEN_DEF) begin
				raise_error(b);
				return;
			end
			if (phase == PH_SIZE && !digits_done) begin
				if (b >= CH_ZERO && b <= CH_NINE) begin
					if (field_len >= SIZE_DIGITS_DEF) begin
						raise_error(b);
						return;
					end
					acc = size_acc * 10 + (b - CH_ZERO);
					size_acc = (acc > SIZE_MAX) ? SIZE_MAX : acc[SIZE_W-1:0];
				end else begin
					digits_done = 1'b1;
				end
			end
			field_len++;
			emit(tag, b, 1'b0, '0, '0, 1'b0, 1'b0);
		endfunction

		function void note_byte(logic [7:0] b);
			bytes_in++;
			case (phase)
				PH_MARK0: begin
					if (b != CH_STAR) begin
						raise_error(b);
					end else begin
						hdr_count = 1;
						size_acc = '0;
						digits_done = 1'b0;
						field_len = '0;
						phase = PH_MARK1;
					end
				end
				PH_MARK1: begin
					if (b != CH_M) begin
						raise_error(b);
					end else begin
						count_hdr();
						if (lead_skip <= 2) begin
							phase = PH_SIZE;
						end else begin
							skip_left = lead_skip - 8'd2;
							phase = PH_LEAD;
						end
					end
				end
				PH_LEAD, PH_MIDDLE: begin
					count_hdr();
					skip_left--;
					if (skip_left == 0)
						phase = (phase == PH_LEAD) ? PH_SIZE : PH_TIME;
				end
				PH_SIZE, PH_ADDR, PH_PORT, PH_TIME: field_byte(b);
				PH_TAIL: begin
					count_hdr();
					skip_left--;
					if (skip_left == 0)
						close_header(b, 1'b0);
				end
				PH_PAYLOAD: begin
					pay_left--;
					if (pay_left == 0)
						phase = PH_TRAILER;
					emit(TAG_PAYLOAD, b, 1'b0, '0, '0, 1'b0, 1'b0);
				end
				PH_TRAILER: begin
					phase = PH_MARK0;
					emit(TAG_TRAILER, b, 1'b0, '0, '0, 1'b0, 1'b1);
				end
				default: ;
			endcase
		endfunction

		function void compare(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: %s mismatch on result %0d: expected %0d, got %0d",
						$realtime, name, checked, want, got);
			end
		endfunction

		function void check_record(res_t got);
			res_t want;
			if (expected_records.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: result with none expected: tag %0d char %0d",
						$realtime, got.field_tag, got.char_value);
				return;
			end
			want = expected_records.pop_front();
			checked++;
			if (want.field_tag == TAG_HDR)
				headers++;
			if (want.record_last)
				trailers++;
			if (want.frame_error)
				errors++;
			compare("field_tag", got.field_tag, want.field_tag);
			compare("char_value", got.char_value, want.char_value);
			compare("field_end", got.field_end, want.field_end);
			compare("payload_len", got.payload_len, want.payload_len);
			compare("header_length", got.header_length, want.header_length);
			compare("frame_error", got.frame_error, want.frame_error);
			compare("record_last", got.record_last, want.record_last);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic hold_off = 1'b0;
	bit   pressure_go = 1'b0;

	crh_byte_if   bytes_ch();
	crh_result_if rec_ch();
	crh_cfg_if    cfg_ch();

	capture_record_header_deframer DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (bytes_ch),
		.records (rec_ch),
		.cfg     (cfg_ch)
	);

	deframe_tracker tracker = new();
	logic [7:0]     stream_q[$];
	logic [7:0]     cur_lead = LEAD_SKIP_RST;
	logic [7:0]     cur_middle = MIDDLE_SKIP_RST;
	logic [7:0]     cur_tail = TAIL_SKIP_RST;
	res_t           seen_record;
	int unsigned    idle_cycles = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [7:0] any_but_slash();
		logic [7:0] b;
		do b = $urandom_range(0, 255); while (b == CH_SLASH);
		return b;
	endfunction

	function automatic logic [7:0] non_digit();
		logic [7:0] b;
		do b = $urandom_range(0, 255); while (b == CH_SLASH || (b >= CH_ZERO && b <= CH_NINE));
		return b;
	endfunction

	function automatic void put_fill(int unsigned len);
		repeat (len) stream_q.push_back($urandom_range(0, 255));
	endfunction

	function automatic void put_field(int unsigned len);
		repeat (len) stream_q.push_back(any_but_slash());
		stream_q.push_back(CH_SLASH);
	endfunction

	function automatic void open_record();
		stream_q.push_back(CH_STAR);
		stream_q.push_back(CH_M);
		put_fill((cur_lead > 2) ? cur_lead - 2 : 0);
	endfunction

	// Queues one record and returns roughly how many results it will produce.
	// A partial record stops after 40 payload bytes and never closes.
	function automatic int unsigned add_record(int unsigned pay, size_form_t form,
			int unsigned addr_len, port_len, time_len, bit partial);
		string digits;
		int unsigned pay_bytes;
		open_record();
		digits = "";
		if (form == SZ_PLAIN || form == SZ_PADDED || form == SZ_SUFFIX)
			digits = $sformatf("%0d", pay);
		else
			pay = 0;
		if (form == SZ_PADDED)
			while (digits.len() < SIZE_DIGITS_DEF) digits = {"0", digits};
		for (int i = 0; i < digits.len(); i++)
			stream_q.push_back(digits[i]);
		// Anything after the first non-digit is tagged but not accumulated.
		if (form == SZ_SUFFIX || form == SZ_PREFIX) begin
			stream_q.push_back(non_digit());
			repeat ($urandom_range(0, 4)) stream_q.push_back(any_but_slash());
		end
		stream_q.push_back(CH_SLASH);
		put_field(addr_len);
		put_field(port_len);
		put_fill(cur_middle);
		put_field(time_len);
		put_fill(cur_tail);
		pay_bytes = partial ? 40 : pay;
		put_fill(pay_bytes);
		if (!partial)
			put_fill(1);
		return addr_len + port_len + time_len + pay_bytes + digits.len() + 6;
	endfunction

	function automatic int unsigned pick_field_len();
		int unsigned sel;
		sel = $urandom_range(0, 19);
		if (sel < 16)
			return $urandom_range(0, 6);
		else if (sel < 19)
			return $urandom_range(7, 31);
		return MAX_FIELD_LEN_DEF;
	endfunction

	function automatic int unsigned random_record();
		int unsigned pay, sel;
		size_form_t form;
		sel = $urandom_range(0, 19);
		if (sel < 14)
			pay = $urandom_range(0, 12);
		else if (sel < 19)
			pay = $urandom_range(13, 80);
		else
			pay = $urandom_range(81, 400);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: form = SZ_PLAIN;
			5: form = SZ_PADDED;
			6, 7: form = SZ_SUFFIX;
			8: form = SZ_PREFIX;
			default: form = SZ_EMPTY;
		endcase
		return add_record(pay, form, pick_field_len(), pick_field_len(), pick_field_len(), 1'b0);
	endfunction

	task automatic push_byte(input logic [7:0] b);
		bytes_ch.valid <= 1'b1;
		bytes_ch.data_byte <= b;
		do @(posedge clk); while (!bytes_ch.ready);
	endtask

	task automatic send_queued();
		int unsigned burst_left, gap;
		burst_left = 0;
		while (stream_q.size() != 0) begin
			if (burst_left == 0) begin
				burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
					: $urandom_range(1, 40);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				if (gap != 0) begin
					bytes_ch.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			push_byte(stream_q.pop_front());
			burst_left--;
		end
		bytes_ch.valid <= 1'b0;
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= v;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic set_skips(input logic [7:0] lead, middle, tail, input bit poke_unused);
		cfg_write(REG_LEAD_SKIP, lead);
		cfg_write(REG_MIDDLE_SKIP, middle);
		cfg_write(REG_TAIL_SKIP, tail);
		if (poke_unused)
			cfg_write(REG_UNUSED, $urandom_range(0, 255));
		cfg_ch.valid <= 1'b0;
		cur_lead = lead;
		cur_middle = middle;
		cur_tail = tail;
	endtask

	// A byte that ends with no result may still be in flight, so allow a short pause.
	task automatic settle();
		while (tracker.expected_records.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin : result_drain
		drain_mode_t mode;
		int unsigned left, tick;
		mode = DRAIN_FULL;
		left = 0;
		tick = 0;
		rec_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				mode = drain_mode_t'($urandom_range(0, 3));
				left = $urandom_range(20, 300);
			end
			left--;
			tick++;
			case (mode)
				DRAIN_FULL: rec_ch.ready <= !hold_off;
				DRAIN_MOSTLY: rec_ch.ready <= !hold_off && ($urandom_range(0, 9) < 7);
				DRAIN_EVERY_FOURTH: rec_ch.ready <= !hold_off && (tick % 4 == 0);
				default: rec_ch.ready <= !hold_off && ($urandom_range(0, 9) < 2);
			endcase
		end
	end

	// One long receiver stall while bytes keep coming, so the output register
	// fills and the block has to push back on its input.
	initial begin : output_hold
		wait (pressure_go);
		repeat ($urandom_range(20, 80)) @(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (bytes_ch.valid && bytes_ch.ready)
				tracker.note_byte(bytes_ch.data_byte);
			if (rec_ch.valid && rec_ch.ready) begin
				seen_record.field_tag = tag_t'(rec_ch.field_tag);
				seen_record.char_value = rec_ch.char_value;
				seen_record.field_end = rec_ch.field_end;
				seen_record.payload_len = rec_ch.payload_len;
				seen_record.header_length = rec_ch.header_length;
				seen_record.frame_error = rec_ch.frame_error;
				seen_record.record_last = rec_ch.record_last;
				tracker.check_record(seen_record);
			end
			if (cfg_ch.valid && cfg_ch.ready)
				tracker.write_reg(cfg_ch.index, cfg_ch.data);
			if ((bytes_ch.valid && bytes_ch.ready) || (rec_ch.valid && rec_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no request moved for %0d cycles, %0d results outstanding",
					$realtime, idle_cycles, tracker.expected_records.size());
				$display("FAIL capture_record_header_deframer");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int unsigned n_records;
		ending_t ending;
		logic [7:0] b;
		bytes_ch.valid <= 1'b0;
		bytes_ch.data_byte <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed records, first with the skips as they come out of reset.
		void'(add_record(5, SZ_PLAIN, 2, 1, 3, 1'b0));
		send_queued();
		settle();
		set_skips(8'd0, 8'd0, 8'd0, 1'b1);
		void'(add_record(0, SZ_EMPTY, 0, 0, 0, 1'b0));
		void'(add_record(12, SZ_SUFFIX, 1, 1, 1, 1'b0));
		void'(add_record(9, SZ_PREFIX, 2, 0, 1, 1'b0));
		void'(add_record(3, SZ_PADDED, MAX_FIELD_LEN_DEF, MAX_FIELD_LEN_DEF,
			MAX_FIELD_LEN_DEF, 1'b0));
		send_queued();
		settle();
		set_skips(8'd1, 8'd255, 8'd255, 1'b0);
		void'(add_record(2, SZ_PLAIN, 1, 1, 1, 1'b0));
		send_queued();
		settle();
		set_skips(8'd2, 8'd1, 8'd0, 1'b0);
		void'(add_record(1, SZ_PLAIN, 0, 0, 0, 1'b0));
		send_queued();
		settle();
		set_skips(8'd255, 8'd0, 8'd1, 1'b0);
		void'(add_record(0, SZ_PLAIN, 1, 1, 1, 1'b0));
		send_queued();
		settle();

		// Random records under a series of skip settings.
		pressure_go = 1'b1;
		n_records = 4;
		while (tracker.bytes_in < ITEM_TARGET) begin
			case ($urandom_range(0, 9))
				0: set_skips($urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 255), $urandom_range(0, 1));
				1: set_skips($urandom_range(0, 1) ? 8'd255 : 8'd2,
					$urandom_range(0, 1) ? 8'd255 : 8'd0,
					$urandom_range(0, 1) ? 8'd255 : 8'd0, 1'b0);
				default: set_skips($urandom_range(0, 6), $urandom_range(0, 5),
					$urandom_range(0, 5), $urandom_range(0, 3) == 0);
			endcase
			repeat (n_records) void'(random_record());
			send_queued();
			settle();
			n_records = $urandom_range(2, 5);
		end

		// The error is sticky until reset, so only one closing case fits in a run.
		ending = ending_t'($urandom_range(0, 4));
		case (ending)
			END_BAD_FIRST: begin
				do b = $urandom_range(0, 255); while (b == CH_STAR);
				stream_q.push_back(b);
			end
			END_BAD_SECOND: begin
				do b = $urandom_range(0, 255); while (b == CH_M);
				stream_q.push_back(CH_STAR);
				stream_q.push_back(b);
			end
			END_LONG_FIELD: begin
				open_record();
				stream_q.push_back(CH_ZERO + 8'd1);
				stream_q.push_back(CH_SLASH);
				repeat (MAX_FIELD_LEN_DEF + 1) stream_q.push_back(any_but_slash());
			end
			END_MANY_DIGITS: begin
				open_record();
				repeat (SIZE_DIGITS_DEF + 1) stream_q.push_back(CH_ZERO + $urandom_range(0, 9));
			end
			default: void'(add_record($urandom_range(8388608, 9999999), SZ_PLAIN, 1, 1, 1, 1'b1));
		endcase
		// After an error the block must stay silent whatever follows.
		if (ending != END_HUGE_SIZE)
			put_fill(20);
		send_queued();
		settle();
		repeat (6) @(posedge clk);

		$display("Covered %0d bytes in, %0d results checked, %0d headers and %0d full records,",
			tracker.bytes_in, tracker.checked, tracker.headers, tracker.trailers);
		$display("closing case %s with %0d error reports.", ending.name(), tracker.errors);
		if (tracker.mismatches == 0 && tracker.expected_records.size() == 0) begin
			$display("PASS capture_record_header_deframer");
		end else begin
			$display("%0d mismatches, %0d results never seen", tracker.mismatches,
				tracker.expected_records.size());
			$display("FAIL capture_record_header_deframer");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/crh_pkg.sv
hdl/crh_if.sv
hdl/crh_cfg_regs.sv
hdl/crh_fsm.sv
hdl/crh_out_reg.sv
hdl/capture_record_header_deframer.sv
dv/capture_record_header_deframer_test.sv
